### hdl/emast_pkg.sv
// emast_pkg: function codes, field widths and shared types of the ema saliency tracker
// no dependencies; used by ema_saliency_top_k_tracker
package emast_pkg;

    localparam int FUNC_W = 3;
    localparam int TOKIN_W = 9;
    localparam int TOKOUT_W = 10;
    localparam int DATA_W = 32;
    localparam int CFG_W = 16;

    typedef logic [FUNC_W-1:0] t_func;

    localparam t_func FUNC_RECORD = 3'd0;
    localparam t_func FUNC_QUERY = 3'd1;
    localparam t_func FUNC_TOP_HIGH = 3'd2;
    localparam t_func FUNC_TOP_LOW = 3'd3;
    localparam t_func FUNC_CLEAR = 3'd4;

    localparam logic CFG_ALPHA = 1'b0;
    localparam logic CFG_MIN_COUNT = 1'b1;

    localparam logic [TOKOUT_W-1:0] TOKEN_NONE = '1;
    localparam logic [CFG_W-1:0] ALPHA_RESET = 16'd6554;
    localparam logic [CFG_W-1:0] MIN_COUNT_RESET = 16'd1;

endpackage

### hdl/ema_saliency_top_k_tracker.sv
// ema_saliency_top_k_tracker: per-token ema mean/variance store with saliency ranking
// depends on emast_pkg

// One item at a time; o_in_stall is high while an item is in work. After reset, and for a
// clear item, a clearing pass writes zero to every entry. A record item takes 7 multiply
// steps on one shared 48x17 multiplier, then an iterative square root and divide to refresh
// that token's stored saliency, then a scan through the single read port of the stores. A
// top highest or top lowest item takes a scan plus TOP_K result transfers; a saliency query
// reads that token's entry. Each result waits in the output register until transferred.
module ema_saliency_top_k_tracker #(
    parameter int NUM_TOKENS = 512,
    parameter int TOP_K = 5
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic                                 i_cfg_addr,
    input  logic [emast_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [emast_pkg::FUNC_W-1:0]         i_func,
    input  logic [emast_pkg::TOKIN_W-1:0]        i_token_index,
    input  logic signed [emast_pkg::DATA_W-1:0]  i_bias_value,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic                                 o_top_changed,
    output logic signed [emast_pkg::TOKOUT_W-1:0] o_token_out,
    output logic signed [emast_pkg::DATA_W-1:0]  o_saliency_out,
    output logic                                 o_last
);

    localparam int AW = (NUM_TOKENS > 1) ? $clog2(NUM_TOKENS) : 1;
    localparam int KW = $clog2(TOP_K + 1);

    localparam logic [4:0] S_CLR  = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_TRD  = 5'd2;
    localparam logic [4:0] S_TLD  = 5'd3;
    localparam logic [4:0] S_MUL  = 5'd4;
    localparam logic [4:0] S_SQI  = 5'd5;
    localparam logic [4:0] S_SQ   = 5'd6;
    localparam logic [4:0] S_DVI  = 5'd7;
    localparam logic [4:0] S_DV   = 5'd8;
    localparam logic [4:0] S_TWR  = 5'd9;
    localparam logic [4:0] S_SRD  = 5'd10;
    localparam logic [4:0] S_SCMP = 5'd11;
    localparam logic [4:0] S_RES  = 5'd12;
    localparam logic [4:0] S_REM  = 5'd13;
    localparam logic [4:0] S_QRD  = 5'd14;
    localparam logic [4:0] S_QLD  = 5'd15;
    localparam logic [4:0] S_OUT  = 5'd16;

    // stores
    logic [31:0] r_mean_mem [NUM_TOKENS];
    logic [31:0] r_var_mem [NUM_TOKENS];
    logic [31:0] r_cnt_mem [NUM_TOKENS];
    logic [31:0] r_sal_mem [NUM_TOKENS];
    logic [31:0] r_rd_mean, r_rd_var, r_rd_cnt, r_rd_sal;

    logic [4:0]  r_state;
    logic [AW-1:0] r_idx;
    logic        r_clr_reply;
    logic [15:0] r_alpha, r_min_count;
    logic [emast_pkg::TOKIN_W-1:0] r_tok;
    logic signed [31:0] r_bias;
    logic        r_is_rec, r_high;
    logic        r_prev_v;
    logic [AW-1:0] r_prev;

    logic signed [31:0] r_mean;
    logic [31:0] r_var, r_cnt;
    logic        r_dneg;
    logic [32:0] r_dmag;
    logic [31:0] r_dsat;
    logic [2:0]  r_step;
    logic [64:0] r_prod;
    logic [48:0] r_acc;
    logic [47:0] r_sq_x, r_sq_res, r_sq_bit;
    logic [5:0]  r_it;
    logic [25:0] r_dv_rem;
    logic [47:0] r_dv_q;
    logic [24:0] r_dv_d;

    logic [AW-1:0] r_ids [TOP_K];
    logic signed [31:0] r_sals [TOP_K];
    logic [KW-1:0] r_n, r_left;

    logic        r_o_valid, r_o_chg, r_o_last;
    logic [emast_pkg::TOKOUT_W-1:0] r_o_tok;
    logic [31:0] r_o_sal;

    logic [AW-1:0] w_tok_addr, w_rd_addr;
    logic        w_we;
    logic [31:0] w_wr_mean, w_wr_var, w_wr_cnt, w_wr_sal;
    logic [AW-1:0] w_wr_addr;
    logic [47:0] w_mul_a;
    logic [16:0] w_mul_b;
    logic signed [32:0] w_dev;
    logic [32:0] w_dmag;
    logic [48:0] w_mceil;
    logic signed [34:0] w_msum;
    logic signed [31:0] w_mnew;
    logic [48:0] w_vsum;
    logic [47:0] w_sq_t;
    logic [25:0] w_dv_sh;
    logic [31:0] w_mabs;
    logic [31:0] w_sal_sat;
    logic        w_qual, w_in_range, w_idx_last;
    logic signed [31:0] w_s;
    logic [AW-1:0] n_ids [TOP_K];
    logic signed [31:0] n_sals [TOP_K];
    logic        w_take_any;
    logic [AW-1:0] w_best;
    logic        w_rec_chg;

    function automatic logic [emast_pkg::TOKOUT_W-1:0] f_tok10(input logic [AW-1:0] idx);
        logic [12:0] t;
        t = 13'(idx);
        return t[emast_pkg::TOKOUT_W-1:0];
    endfunction

    assign w_tok_addr = AW'(r_tok);
    assign w_in_range = 13'(i_token_index) < 13'(NUM_TOKENS);
    assign w_idx_last = (r_idx == AW'(NUM_TOKENS - 1));
    assign w_qual = (r_rd_cnt >= 32'(r_min_count));
    assign w_s = r_rd_sal;

    assign o_in_stall = (r_state != S_IDLE);
    assign o_out_valid = r_o_valid;
    assign o_top_changed = r_o_chg;
    assign o_token_out = r_o_tok;
    assign o_saliency_out = r_o_sal;
    assign o_last = r_o_last;

    // read port
    assign w_rd_addr = (r_state == S_SRD) ? r_idx : w_tok_addr;

    always_ff @(posedge i_clk) begin
        r_rd_mean <= r_mean_mem[w_rd_addr];
        r_rd_var <= r_var_mem[w_rd_addr];
        r_rd_cnt <= r_cnt_mem[w_rd_addr];
        r_rd_sal <= r_sal_mem[w_rd_addr];
    end

    // write port
    always_comb begin
        w_we = 1'b0;
        w_wr_addr = r_idx;
        w_wr_mean = '0;
        w_wr_var = '0;
        w_wr_cnt = '0;
        w_wr_sal = '0;
        if (r_state == S_CLR) begin
            w_we = 1'b1;
        end else if (r_state == S_TWR) begin
            w_we = 1'b1;
            w_wr_addr = w_tok_addr;
            w_wr_mean = r_mean;
            w_wr_var = r_var;
            w_wr_cnt = r_cnt;
            w_wr_sal = w_sal_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mean_mem[w_wr_addr] <= w_wr_mean;
            r_var_mem[w_wr_addr] <= w_wr_var;
            r_cnt_mem[w_wr_addr] <= w_wr_cnt;
            r_sal_mem[w_wr_addr] <= w_wr_sal;
        end
    end

    // deviation of the sample from the stored mean
    assign w_dev = {r_bias[31], r_bias} - {r_rd_mean[31], r_rd_mean};
    assign w_dmag = w_dev[32] ? 33'(-w_dev) : 33'(w_dev);

    // shared multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (r_step)
            3'd0: begin
                w_mul_a = 48'(r_dmag);
                w_mul_b = {1'b0, r_alpha};
            end
            3'd1: begin
                w_mul_a = 48'(r_dsat);
                w_mul_b = {1'b0, r_dsat[31:16]};
            end
            3'd2: begin
                w_mul_a = 48'(r_dsat);
                w_mul_b = {1'b0, r_dsat[15:0]};
            end
            3'd4: begin
                w_mul_a = r_acc[47:0];
                w_mul_b = {1'b0, r_alpha};
            end
            3'd5: begin
                w_mul_a = 48'(r_var);
                w_mul_b = 17'h10000 - {1'b0, r_alpha};
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // mean update with floor shift and saturation
    assign w_mceil = r_prod[48:0] + 49'h0FFFF;
    assign w_msum = r_dneg ? ({{3{r_mean[31]}}, r_mean} - 35'(w_mceil[48:16]))
                           : ({{3{r_mean[31]}}, r_mean} + 35'(r_prod[48:16]));
    always_comb begin
        if (w_msum > 35'sd2147483647) begin
            w_mnew = 32'sh7FFFFFFF;
        end else if (w_msum < -35'sd2147483648) begin
            w_mnew = 32'sh80000000;
        end else begin
            w_mnew = w_msum[31:0];
        end
    end

    assign w_vsum = r_acc + 49'(r_prod[64:16]);
    assign w_sq_t = r_sq_res + r_sq_bit;
    assign w_dv_sh = {r_dv_rem[24:0], r_dv_q[47]};
    assign w_mabs = r_mean[31] ? 32'(-r_mean) : 32'(r_mean);

    always_comb begin
        if (r_mean[31]) begin
            w_sal_sat = (r_dv_q > 48'h0000_8000_0000) ? 32'h8000_0000 : 32'(-r_dv_q[31:0]);
        end else begin
            w_sal_sat = (r_dv_q > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : r_dv_q[31:0];
        end
    end

    // ranked insertion into the slot list
    always_comb begin
        logic placed;
        logic take;
        placed = 1'b0;
        for (int k = 0; k < TOP_K; k++) begin
            take = (KW'(k) >= r_n) || (r_high ? (w_s > r_sals[k]) : (w_s < r_sals[k]));
            if (placed) begin
                n_ids[k] = r_ids[(k > 0) ? k - 1 : 0];
                n_sals[k] = r_sals[(k > 0) ? k - 1 : 0];
            end else if (take) begin
                n_ids[k] = r_idx;
                n_sals[k] = w_s;
            end else begin
                n_ids[k] = r_ids[k];
                n_sals[k] = r_sals[k];
            end
            placed = placed | take;
        end
        w_take_any = placed;
    end

    assign w_best = r_ids[0];
    assign w_rec_chg = (r_n != '0) && !(r_prev_v && (r_prev == w_best));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_idx <= '0;
            r_clr_reply <= 1'b0;
            r_prev_v <= 1'b0;
            r_alpha <= emast_pkg::ALPHA_RESET;
            r_min_count <= emast_pkg::MIN_COUNT_RESET;
            r_o_valid <= 1'b0;
            r_step <= '0;
            r_it <= '0;
            r_n <= '0;
            r_left <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    emast_pkg::CFG_ALPHA: r_alpha <= i_cfg_data;
                    emast_pkg::CFG_MIN_COUNT: r_min_count <= i_cfg_data;
                    default: r_alpha <= r_alpha;
                endcase
            end
            unique case (r_state)
                S_CLR: begin
                    r_idx <= r_idx + 1'b1;
                    if (w_idx_last) begin
                        r_idx <= '0;
                        r_prev_v <= 1'b0;
                        if (r_clr_reply) begin
                            r_o_valid <= 1'b1;
                            r_o_chg <= 1'b0;
                            r_o_tok <= emast_pkg::TOKEN_NONE;
                            r_o_sal <= '0;
                            r_o_last <= 1'b1;
                            r_left <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_tok <= i_token_index;
                        r_bias <= i_bias_value;
                        r_idx <= '0;
                        r_n <= '0;
                        r_left <= '0;
                        unique case (i_func) inside
                            emast_pkg::FUNC_RECORD, emast_pkg::FUNC_QUERY: begin
                                if (!w_in_range) begin
                                    r_o_valid <= 1'b1;
                                    r_o_chg <= 1'b0;
                                    r_o_tok <= emast_pkg::TOKEN_NONE;
                                    r_o_sal <= '0;
                                    r_o_last <= 1'b1;
                                    r_state <= S_OUT;
                                end else if (i_func == emast_pkg::FUNC_RECORD) begin
                                    r_is_rec <= 1'b1;
                                    r_high <= 1'b1;
                                    r_state <= S_TRD;
                                end else begin
                                    r_state <= S_QRD;
                                end
                            end
                            emast_pkg::FUNC_TOP_HIGH, emast_pkg::FUNC_TOP_LOW: begin
                                r_is_rec <= 1'b0;
                                r_high <= (i_func == emast_pkg::FUNC_TOP_HIGH);
                                r_state <= S_SRD;
                            end
                            emast_pkg::FUNC_CLEAR: begin
                                r_clr_reply <= 1'b1;
                                r_state <= S_CLR;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_TRD: r_state <= S_TLD;
                S_TLD: begin
                    r_mean <= r_rd_mean;
                    r_var <= r_rd_var;
                    r_cnt <= (r_rd_cnt == 32'hFFFF_FFFF) ? r_rd_cnt : r_rd_cnt + 32'd1;
                    r_dneg <= w_dev[32];
                    r_dmag <= w_dmag;
                    r_dsat <= w_dmag[32] ? 32'hFFFF_FFFF : w_dmag[31:0];
                    r_step <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= w_mul_a * w_mul_b;
                    r_step <= r_step + 3'd1;
                    case (r_step)
                        3'd1: r_mean <= w_mnew;
                        3'd2: r_acc <= r_prod[48:0];
                        3'd3: r_acc <= r_acc + 49'(r_prod[64:16]);
                        3'd5: r_acc <= r_prod[64:16];
                        3'd6: begin
                            r_var <= (w_vsum > 49'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : w_vsum[31:0];
                            r_state <= S_SQI;
                        end
                        default: r_acc <= r_acc;
                    endcase
                end
                S_SQI: begin
                    r_sq_x <= {r_var[31:0], 16'h0000};
                    r_sq_res <= '0;
                    r_sq_bit <= 48'h4000_0000_0000;
                    r_it <= '0;
                    r_state <= S_SQ;
                end
                S_SQ: begin
                    if (r_sq_x >= w_sq_t) begin
                        r_sq_x <= r_sq_x - w_sq_t;
                        r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                    end else begin
                        r_sq_res <= r_sq_res >> 1;
                    end
                    r_sq_bit <= r_sq_bit >> 2;
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'd23) begin
                        r_state <= S_DVI;
                    end
                end
                S_DVI: begin
                    r_dv_d <= {1'b0, r_sq_res[23:0]} + 25'd1;
                    r_dv_q <= {w_mabs, 16'h0000};
                    r_dv_rem <= '0;
                    r_it <= '0;
                    r_state <= S_DV;
                end
                S_DV: begin
                    if (w_dv_sh >= {1'b0, r_dv_d}) begin
                        r_dv_rem <= w_dv_sh - {1'b0, r_dv_d};
                        r_dv_q <= {r_dv_q[46:0], 1'b1};
                    end else begin
                        r_dv_rem <= w_dv_sh;
                        r_dv_q <= {r_dv_q[46:0], 1'b0};
                    end
                    r_it <= r_it + 6'd1;
                    if (r_it == 6'd47) begin
                        r_state <= S_TWR;
                    end
                end
                S_TWR: begin
                    r_idx <= '0;
                    r_n <= '0;
                    r_state <= S_SRD;
                end
                S_SRD: r_state <= S_SCMP;
                S_SCMP: begin
                    if (w_qual && w_take_any) begin
                        for (int k = 0; k < TOP_K; k++) begin
                            r_ids[k] <= n_ids[k];
                            r_sals[k] <= n_sals[k];
                        end
                        if (r_n != KW'(TOP_K)) begin
                            r_n <= r_n + 1'b1;
                        end
                    end
                    r_idx <= r_idx + 1'b1;
                    if (w_idx_last) begin
                        r_idx <= '0;
                        r_left <= KW'(TOP_K);
                        r_state <= r_is_rec ? S_RES : S_REM;
                    end else begin
                        r_state <= S_SRD;
                    end
                end
                S_RES: begin
                    if (w_rec_chg) begin
                        r_prev_v <= 1'b1;
                        r_prev <= w_best;
                    end
                    r_o_valid <= 1'b1;
                    r_o_chg <= w_rec_chg;
                    r_o_tok <= (r_n != '0) ? f_tok10(w_best) : emast_pkg::TOKEN_NONE;
                    r_o_sal <= (r_n != '0) ? r_sals[0] : '0;
                    r_o_last <= 1'b1;
                    r_left <= '0;
                    r_state <= S_OUT;
                end
                S_REM: begin
                    r_o_valid <= 1'b1;
                    r_o_chg <= 1'b0;
                    r_o_tok <= (r_n != '0) ? f_tok10(r_ids[0]) : emast_pkg::TOKEN_NONE;
                    r_o_sal <= (r_n != '0) ? r_sals[0] : '0;
                    r_o_last <= (r_left == KW'(1));
                    r_left <= r_left - 1'b1;
                    for (int k = 0; k < TOP_K - 1; k++) begin
                        r_ids[k] <= r_ids[k + 1];
                        r_sals[k] <= r_sals[k + 1];
                    end
                    if (r_n != '0) begin
                        r_n <= r_n - 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_QRD: r_state <= S_QLD;
                S_QLD: begin
                    r_o_valid <= 1'b1;
                    r_o_chg <= 1'b0;
                    r_o_tok <= {1'b0, r_tok};
                    r_o_sal <= w_qual ? r_rd_sal : '0;
                    r_o_last <= 1'b1;
                    r_left <= '0;
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_out_stall) begin
                        r_o_valid <= 1'b0;
                        r_state <= (r_left != '0) ? S_REM : S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
